@@ rtl/core/stxack_pkg.sv @@
// stxack_pkg: shared constants, types and the fixed acknowledge text
// for the stx/etx deframer with acknowledge; no dependencies
package stxack_pkg;

  localparam int BYTE_W          = 8;
  localparam int HDR_LEN         = 15;
  localparam int HDR_IDX_W       = $clog2(HDR_LEN);
  localparam int ACK_LEN         = 27;
  localparam int ACK_IDX_W       = $clog2(ACK_LEN);
  localparam int TEXT_LEN        = 10;
  localparam int MIN_FLOOR       = 16;
  localparam int CNT_W           = 12;
  localparam int FRAME_LIMIT_DEF = 2048;
  localparam int CFG_IDX_W       = 2;

  localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h53;
  localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h45;
  localparam logic [BYTE_W-1:0] MIN_LENGTH_RST = 8'd16;

  // ascii "999ACK-MSG"
  localparam logic [BYTE_W-1:0] ACK_TEXT [TEXT_LEN] = '{
    8'h39, 8'h39, 8'h39, 8'h41, 8'h43, 8'h4B, 8'h2D, 8'h4D, 8'h53, 8'h47
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CHAR = 2'd0,
    CFG_END_CHAR   = 2'd1,
    CFG_MIN_LENGTH = 2'd2
  } cfg_idx_t;

  typedef logic [HDR_LEN-1:0][BYTE_W-1:0] hdr_t;

  // deframer to emitter: start an acknowledge with this header copy
  typedef struct packed {
    logic load;
    hdr_t hdr;
  } ack_req_t;

endpackage

@@ rtl/core/stxack_deframer.sv @@
// stxack_deframer: frame tracking, body count and header capture
// depends on stxack_pkg
module stxack_deframer #(
  parameter int FRAME_LIMIT = stxack_pkg::FRAME_LIMIT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [stxack_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                         in_stall,
  input  logic [stxack_pkg::BYTE_W-1:0] start_char,
  input  logic [stxack_pkg::BYTE_W-1:0] end_char,
  input  logic [stxack_pkg::BYTE_W-1:0] min_length,
  input  logic                         emit_busy,
  output stxack_pkg::ack_req_t         ack_req
);
  import stxack_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic [CNT_W-1:0]  body_count_r, body_count_nxt;
  hdr_t              hdr_r;
  logic [BYTE_W-1:0] need;
  logic              is_start, is_end, ack_due, fire, body_wr;

  assign need     = (min_length < BYTE_W'(MIN_FLOOR)) ? BYTE_W'(MIN_FLOOR) : min_length;
  assign is_start = (in_rx_byte == start_char);
  assign is_end   = (in_rx_byte == end_char) && !is_start;
  assign ack_due  = in_frame_r && is_end && (body_count_r >= CNT_W'(need));
  // only an end byte that earns an ack waits for the emitter
  assign in_stall = emit_busy && ack_due;
  assign fire     = in_valid && !in_stall;
  assign body_wr  = fire && in_frame_r && !is_start && !is_end;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    body_count_nxt = body_count_r;
    if (fire) begin
      if (is_start) begin
        in_frame_nxt   = 1'b1;
        body_count_nxt = '0;
      end else if (in_frame_r) begin
        if (is_end) begin
          in_frame_nxt = 1'b0;
        end else if (body_count_r < CNT_W'(FRAME_LIMIT)) begin
          body_count_nxt = body_count_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      body_count_r <= '0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      body_count_r <= body_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (body_wr && (body_count_r < CNT_W'(HDR_LEN))) begin
      hdr_r[body_count_r[HDR_IDX_W-1:0]] <= in_rx_byte;
    end
  end

  assign ack_req.load = fire && ack_due;
  assign ack_req.hdr  = hdr_r;

endmodule

@@ rtl/core/stxack_emitter.sv @@
// stxack_emitter: header snapshot, byte sequencer and output register
// depends on stxack_pkg
module stxack_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stxack_pkg::ack_req_t         ack_req,
  input  logic [stxack_pkg::BYTE_W-1:0] start_char,
  input  logic [stxack_pkg::BYTE_W-1:0] end_char,
  output logic                         emit_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [stxack_pkg::BYTE_W-1:0] out_ack_byte,
  output logic                         out_ack_last
);
  import stxack_pkg::*;

  hdr_t                 snap_r;
  logic                 busy_r, busy_nxt;
  logic [ACK_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_last_r;
  logic [BYTE_W-1:0]    frame [ACK_LEN];
  logic                 adv, step, at_end;

  // acknowledge layout: start, dst addr, src addr, text, msg code, end
  always_comb begin
    frame[0] = start_char;
    for (int k = 0; k < 6; k++) begin
      frame[1 + k] = snap_r[6 + k];
      frame[7 + k] = snap_r[k];
    end
    for (int k = 0; k < TEXT_LEN; k++) begin
      frame[13 + k] = ACK_TEXT[k];
    end
    for (int k = 0; k < 3; k++) begin
      frame[23 + k] = snap_r[12 + k];
    end
    frame[ACK_LEN-1] = end_char;
  end

  assign adv    = !out_valid_r || !out_stall;
  assign step   = busy_r && adv;
  assign at_end = (idx_r == ACK_IDX_W'(ACK_LEN - 1));

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + ACK_IDX_W'(1);
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
    if (ack_req.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack_req.load) begin
      snap_r <= ack_req.hdr;
    end
    if (step) begin
      out_byte_r <= frame[idx_r];
      out_last_r <= at_end;
    end
  end

  assign emit_busy    = busy_r;
  assign out_valid    = out_valid_r;
  assign out_ack_byte = out_byte_r;
  assign out_ack_last = out_last_r;

endmodule

@@ rtl/core/stx_etx_deframer_with_ack.sv @@
// stx_etx_deframer_with_ack: top level, configuration registers and checks
// depends on stxack_pkg, stxack_deframer, stxack_emitter
//
// usage
// - input channel: one received byte per request (in_rx_byte), taken when
//   in_valid is high and in_stall is low; a byte per cycle unless stalled
// - a start byte opens a frame (also inside one) and clears the count; body
//   bytes are counted and the first 15 kept as header; an end byte closes
//   the frame and, if the body was long enough, starts a 27-byte ack
// - result channel: one ack byte per request (out_ack_byte, out_ack_last on
//   the final byte), taken when out_valid is high and out_stall is low
// - ack output: the taken end byte sets the sequencer busy, then the first
//   ack byte is registered out; one byte per cycle unless the receiver stalls
// - throughput: one input byte per cycle; the ack sequencer holds one ack
//   at a time, so an end byte that earns a further ack is stalled until
//   the previous ack has left the sequencer (other bytes flow on)
// - receiver stall holds the output register and the sequencer; input
//   keeps flowing until an ack-earning end byte meets a busy sequencer
// - config port: cfg_index/cfg_data written on cfg_valid (cfg_ready is
//   always high); index 0 start char, 1 end char, 2 min length, others
//   ignored; write only while idle
// - reset (synchronous, rst_n low): no frame open, count zero, no ack
//   pending, config back to 'S', 'E' and 16
module stx_etx_deframer_with_ack #(
  parameter int FRAME_LIMIT = stxack_pkg::FRAME_LIMIT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [stxack_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [stxack_pkg::BYTE_W-1:0]    out_ack_byte,
  output logic                            out_ack_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stxack_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stxack_pkg::BYTE_W-1:0]    cfg_data
);
  import stxack_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] start_char_r, start_char_nxt;
  logic [BYTE_W-1:0] end_char_r, end_char_nxt;
  logic [BYTE_W-1:0] min_length_r, min_length_nxt;

  ack_req_t ack_req;
  logic     emit_busy;

  assign cfg_ready = 1'b1;

  always_comb begin
    start_char_nxt = start_char_r;
    end_char_nxt   = end_char_r;
    min_length_nxt = min_length_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_CHAR: start_char_nxt = cfg_data;
        CFG_END_CHAR:   end_char_nxt   = cfg_data;
        CFG_MIN_LENGTH: min_length_nxt = cfg_data;
        default:        ;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
      min_length_r <= MIN_LENGTH_RST;
    end else begin
      start_char_r <= start_char_nxt;
      end_char_r   <= end_char_nxt;
      min_length_r <= min_length_nxt;
    end
  end

  // frame tracking and header capture
  stxack_deframer #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .start_char (start_char_r),
    .end_char   (end_char_r),
    .min_length (min_length_r),
    .emit_busy  (emit_busy),
    .ack_req    (ack_req)
  );

  // ack sequencer with output register
  stxack_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .ack_req      (ack_req),
    .start_char   (start_char_r),
    .end_char     (end_char_r),
    .emit_busy    (emit_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ack_byte (out_ack_byte),
    .out_ack_last (out_ack_last)
  );

  // a new ack never starts over one still being sequenced
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ack_req.load |-> !emit_busy)
    else $error("ack load while sequencer busy");

  // accepted ack request always starts the sequencer
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ack_req.load |=> emit_busy)
    else $error("ack load did not start sequencer");

  // input only waits on a busy sequencer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> emit_busy)
    else $error("input stalled with idle sequencer");

endmodule

@@ sim/stx_etx_deframer_with_ack_tb.sv @@
// stx_etx_deframer_with_ack_tb: self-checking bench for the stx/etx deframer
// with acknowledge; needs stxack_pkg and the block's rtl, nothing else
// random byte streams against an in-bench ack predictor, several char setups
module stx_etx_deframer_with_ack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stxack_pkg::*;

  localparam int FRAME_LIMIT = 2048;
  localparam int HDR_BYTES = 15;
  localparam int ACK_BYTES = 27;
  localparam int SHORTEST_BODY = 16;
  localparam string ACK_WORD = "999ACK-MSG";
  localparam logic [7:0] START_DEFAULT = 8'h53;
  localparam logic [7:0] END_DEFAULT = 8'h45;
  // index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // ack predictor plus queue of ack bytes still owed by the block
  class ack_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       last;
    } ack_beat_t;

    int limit;
    int errors;
    logic [7:0] start_ch;
    logic [7:0] end_ch;
    logic [7:0] min_len;
    bit open;
    int body_cnt;
    logic [7:0] hdr [HDR_BYTES];
    ack_beat_t due [$];

    function new(int frame_limit);
      limit = frame_limit;
      errors = 0;
      start_ch = START_DEFAULT;
      end_ch = END_DEFAULT;
      min_len = 8'd16;
      open = 0;
      body_cnt = 0;
      foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        CFG_START_CHAR: start_ch = v;
        CFG_END_CHAR:   end_ch = v;
        CFG_MIN_LENGTH: min_len = v;
        default: ;
      endcase
    endfunction

    // min length below 16 still needs 16 body bytes, more than a full header
    function int need_len();
      return (min_len < SHORTEST_BODY) ? SHORTEST_BODY : min_len;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_byte(logic [7:0] b);
      string word;
      logic [7:0] beat;
      word = ACK_WORD;
      if (b == start_ch) begin
        // start wins over end when both chars match
        body_cnt = 0;
        open = 1;
      end else if (open && b == end_ch) begin
        open = 0;
        if (body_cnt >= need_len()) begin
          for (int k = 0; k < ACK_BYTES; k++) begin
            if (k == 0) beat = start_ch;
            else if (k <= 6) beat = hdr[k + 5];     // destination goes first
            else if (k <= 12) beat = hdr[k - 7];    // then source
            else if (k <= 22) beat = word[k - 13];
            else if (k <= 25) beat = hdr[k - 11];   // message code
            else beat = end_ch;
            due.push_back('{data: beat, last: (k == ACK_BYTES - 1)});
          end
        end
      end else if (open) begin
        if (body_cnt < HDR_BYTES) hdr[body_cnt] = b;
        if (body_cnt < limit) body_cnt++;
      end
    endfunction

    function void check_ack(logic [7:0] data, logic last);
      ack_beat_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: ack byte expected none, got %h (last %b)", $time, data, last);
      end else begin
        want = due.pop_front();
        if (want.data !== data) begin
          errors++;
          $display("%0t: ack_byte expected %h, got %h", $time, want.data, data);
        end
        if (want.last !== last) begin
          errors++;
          $display("%0t: ack_last expected %b, got %b", $time, want.last, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_ack_byte;
  logic out_ack_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = 8'h00;

  // calm: no idling on either side
  logic calm = 1'b0;
  int fed = 0;

  ack_scoreboard sb = new(FRAME_LIMIT);

  stx_etx_deframer_with_ack #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_ack_byte(out_ack_byte),
    .out_ack_last(out_ack_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver backpressure on roughly 7 percent of cycles
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 7);
  end

  // every ack byte taken is compared with the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_ack(out_ack_byte, out_ack_last);
  end

  // one received byte per request; valid stays up across back-to-back bytes
  task automatic put_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    fed++;
  endtask

  // body byte that neither opens nor closes a frame
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == sb.start_ch || b == sb.end_ch) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send_frame(input int len);
    put_byte(sb.start_ch);
    repeat (len) put_byte(body_byte());
    put_byte(sb.end_ch);
  endtask

  // wait until every owed ack byte is out, then past the ack latency
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // only touched while the block is idle
  task automatic configure(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m);
    drain();
    write_reg(CFG_NO_REG, ~s);
    write_reg(CFG_START_CHAR, s);
    write_reg(CFG_END_CHAR, e);
    write_reg(CFG_MIN_LENGTH, m);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed frames around the length threshold, plus restarts,
  // stray bytes and frames full of arbitrary bytes
  task automatic run_phase(input int budget);
    int base;
    int r;
    int need;
    base = fed;
    while (fed - base < budget) begin
      r = $urandom_range(0, 99);
      need = sb.need_len();
      if (r < 65) begin
        send_frame(need - 2 + $urandom_range(0, 8));
      end else if (r < 75) begin
        put_byte(sb.start_ch);
        repeat ($urandom_range(0, 5)) put_byte(body_byte());
        send_frame(need - 2 + $urandom_range(0, 8));
      end else if (r < 87) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        put_byte(sb.start_ch);
        repeat ($urandom_range(0, 20)) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: stray end and data outside a frame, a restart inside an
    // open frame, then a minimum-length frame with extreme header bytes
    put_byte(END_DEFAULT);
    put_byte(8'hFF);
    put_byte(START_DEFAULT);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(START_DEFAULT);
    for (int k = 0; k < 16; k++) put_byte(k[0] ? (8'hF0 | 8'(k)) : 8'(k));
    put_byte(END_DEFAULT);

    // random phases over several char and length setups
    configure(START_DEFAULT, END_DEFAULT, 8'd16);
    run_phase(45);
    calm <= 1'b1;
    configure(8'h00, 8'hFF, 8'd0);      // min length below the floor
    run_phase(45);
    calm <= 1'b0;
    configure(8'hFF, 8'h00, 8'd21);
    run_phase(45);
    configure(8'h5A, 8'h5A, 8'd16);     // same char for start and end, start wins
    run_phase(20);

    // raised min length, one byte short and exactly enough
    configure(8'h7E, 8'h0D, 8'd30);
    send_frame(29);
    send_frame(30);
    drain();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/stxack_pkg.sv
rtl/core/stxack_deframer.sv
rtl/core/stxack_emitter.sv
rtl/core/stx_etx_deframer_with_ack.sv
sim/stx_etx_deframer_with_ack_tb.sv
